FILE: rtl/cma_pkg.sv
// Package for the confusion matrix accumulator.
// Holds mode codes, field widths and the report row type; no dependencies.
package cma_pkg;
	localparam logic [1:0] MODE_PAIR   = 2'd0;
	localparam logic [1:0] MODE_MISS   = 2'd1;
	localparam logic [1:0] MODE_REPORT = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	localparam int LABEL_W = 5;
	localparam int FIELD_W = 32;
	localparam int RATIO_W = 17;

	typedef struct packed {
		logic              last;
		logic [2:0]        ratio_valid;
		logic [RATIO_W-1:0] fscore_q16;
		logic [RATIO_W-1:0] precision_q16;
		logic [RATIO_W-1:0] recall_q16;
		logic [FIELD_W-1:0] row_total;
		logic [FIELD_W-1:0] missing_count;
		logic [FIELD_W-1:0] false_pos;
		logic [FIELD_W-1:0] false_neg;
		logic [FIELD_W-1:0] true_pos;
		logic [LABEL_W-1:0] class_index;
	} row_t;
endpackage

FILE: rtl/confusion_matrix_accumulator_top.sv
// Top level of the confusion matrix accumulator: counter memory, sequencer and
// one shared add/compare unit. Depends on cma_pkg.
//
// A count (mode 0 or 1) goes through transfer, memory read, read data, and
// increment and write back. A clear sweeps the whole memory one entry a
// cycle. A report reads the memory through its single read port, one entry
// at a time: each class row sums 2K+1 entries (row r, column r and the
// missing entry), then runs three divisions (recall, precision, F1) on the
// shared sequential restoring divider before its output; the overall row
// follows with one division. After reset a clearing pass over the whole
// memory runs before the first item is accepted. The block takes one item at
// a time; s_tready is low while it works or while a report row waits in the
// output register.
module confusion_matrix_accumulator_top #(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,   // class_count_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // mode[1:0], ref_label[6:2], pred_label[11:7], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [215:0] m_tdata,    // class_index, true_pos, false_neg, false_pos,
	                                 // missing_count, row_total, recall, precision, fscore
	output logic [2:0]  m_tuser,     // ratio_valid
	output logic        m_tlast
);
	import cma_pkg::*;

	localparam int NCOLS = MAX_CLASSES + 1;
	localparam int DEPTH = MAX_CLASSES * NCOLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(NCOLS + 1);
	// Sums over up to MAX_CLASSES^2 counters, doubled for F1.
	localparam int SW    = COUNT_BITS + 2 * $clog2(MAX_CLASSES) + 3;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	localparam logic [4:0]
		ST_INIT = 5'd0, ST_IDLE = 5'd1, ST_CRD = 5'd2, ST_CDAT = 5'd3, ST_CWR = 5'd4,
		ST_CLR = 5'd5, ST_RSTART = 5'd6, ST_RDAT = 5'd7, ST_ACC = 5'd8,
		ST_DIVSET = 5'd9, ST_DIV = 5'd10, ST_DIVEND = 5'd11, ST_OUT = 5'd12,
		ST_WAIT = 5'd13, ST_OVR = 5'd14, ST_RDIAG = 5'd15, ST_ADIAG = 5'd16;

	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	logic [COUNT_BITS-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	logic [4:0]  state_q;
	logic [4:0]  kreg_q;
	logic [CW-1:0] k;
	logic [AW-1:0] cnt_q, addr_q;
	logic [CW-1:0] r_q, p_q;
	logic [1:0]  phase_q;   // 0 row pass, 1 column pass, 2 missing
	logic [SW-1:0] tp_q, fn_q, fp_q, miss_q, rs_q, diag_q, tot_q;
	logic [SW-1:0] num_q, den_q, rem_q;
	logic [16:0] quo_q;
	logic [4:0]  it_q;
	logic [1:0]  div_sel_q;
	logic [16:0] rec_q, pre_q, f1_q;
	logic [2:0]  val_q;
	logic        ovr_q;
	row_t        out_q;
	logic        ovalid_q;

	logic [4:0] kc;
	always_comb begin
		kc = kreg_q;
		if (kreg_q == 5'd0) kc = 5'd1;
		if ({27'd0, kreg_q} > MAX_CLASSES) kc = 5'(MAX_CLASSES);
	end
	assign k = CW'(kc);

	logic signed [4:0] rl, pl;
	assign rl = s_tdata[6:2];
	assign pl = s_tdata[11:7];

	function automatic logic [AW-1:0] idx(input logic [CW-1:0] r, input logic [CW-1:0] c);
		idx = AW'(r * NCOLS + c);
	endfunction

	function automatic logic [31:0] sat(input logic [SW-1:0] v);
		sat = (v > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Shared adder: the running row and column sums and the divider subtract
	// go through it.
	logic [SW-1:0] add_a, add_b, add_y;
	logic          add_sub;
	assign add_y = add_sub ? add_a - add_b : add_a + add_b;

	logic [SW-1:0] rd_ext;
	assign rd_ext = SW'(rdata_q);

	always_comb begin
		raddr = addr_q; we = 1'b0; waddr = addr_q; wdata = '0;
		add_a = '0; add_b = '0; add_sub = 1'b0;
		case (state_q)
			ST_INIT, ST_CLR: begin we = 1'b1; waddr = cnt_q; end
			ST_CWR: begin
				we = 1'b1;
				wdata = (rdata_q == CMAX) ? rdata_q : rdata_q + 1'b1;
			end
			ST_ACC, ST_ADIAG: begin
				add_a = (phase_q == 2'd1) ? fp_q : rs_q; add_b = rd_ext;
			end
			ST_DIV: begin add_a = {rem_q[SW-2:0], 1'b0}; add_b = den_q; add_sub = 1'b1; end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	wire s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT; kreg_q <= 5'd16; cnt_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) kreg_q <= cfg_wdata;
			// In ST_OUT the output register is reloaded below instead.
			if (ovalid_q && m_tready && state_q != ST_OUT) ovalid_q <= 1'b0;
			case (state_q)
				ST_INIT, ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(DEPTH - 1)) begin cnt_q <= '0; state_q <= ST_IDLE; end
				end
				ST_IDLE: if (s_acc) begin
					case (s_tdata[1:0])
						MODE_PAIR: if (rl >= 0 && pl >= 0 && CW'(rl) < k && CW'(pl) < k) begin
							addr_q <= idx(CW'(rl), CW'(pl)); state_q <= ST_CRD;
						end
						MODE_MISS: if (rl >= 0 && CW'(rl) < k) begin
							addr_q <= idx(CW'(rl), CW'(MAX_CLASSES)); state_q <= ST_CRD;
						end
						MODE_CLEAR: begin cnt_q <= '0; state_q <= ST_CLR; end
						default: begin
							r_q <= '0; diag_q <= '0; tot_q <= '0; state_q <= ST_RSTART;
						end
					endcase
				end
				ST_CRD:  state_q <= ST_CDAT;
				ST_CDAT: state_q <= ST_CWR;
				ST_CWR:  state_q <= ST_IDLE;
				ST_RSTART: begin
					// Row pass first: sum row r, then column r, then missing entry.
					p_q <= '0; phase_q <= 2'd0; rs_q <= '0; fp_q <= '0;
					addr_q <= idx(r_q, '0); state_q <= ST_RDAT;
				end
				ST_RDAT: state_q <= ST_ACC;
				ST_ACC: begin
					if (phase_q == 2'd0) begin
						rs_q <= add_y;
						if (p_q == r_q) tp_q <= rd_ext;
						if (p_q == k - 1'b1) begin
							phase_q <= 2'd1; p_q <= '0; addr_q <= idx('0, r_q);
						end else begin
							p_q <= p_q + 1'b1; addr_q <= idx(r_q, p_q + 1'b1);
						end
						state_q <= ST_RDAT;
					end else if (phase_q == 2'd1) begin
						if (p_q != r_q) fp_q <= add_y;
						if (p_q == k - 1'b1) begin
							phase_q <= 2'd2; addr_q <= idx(r_q, CW'(MAX_CLASSES));
						end else begin
							p_q <= p_q + 1'b1; addr_q <= idx(p_q + 1'b1, r_q);
						end
						state_q <= ST_RDAT;
					end else begin
						miss_q <= rd_ext;
						fn_q <= rs_q - tp_q + rd_ext;
						diag_q <= diag_q + tp_q;
						tot_q <= tot_q + rs_q;
						div_sel_q <= 2'd0; ovr_q <= 1'b0;
						state_q <= ST_DIVSET;
					end
				end
				ST_DIVSET: begin
					case (div_sel_q)
						2'd0: begin num_q <= ovr_q ? diag_q : tp_q;
							den_q <= ovr_q ? tot_q : tp_q + fn_q; end
						2'd1: begin num_q <= tp_q; den_q <= tp_q + fp_q; end
						default: begin num_q <= tp_q << 1;
							den_q <= (tp_q << 1) + fp_q + fn_q; end
					endcase
					it_q <= '0; quo_q <= '0; state_q <= ST_DIV;
					rem_q <= ovr_q ? diag_q : ((div_sel_q == 2'd2) ? tp_q << 1 : tp_q);
				end
				ST_DIV: begin
					if (den_q == '0 || num_q >= den_q) state_q <= ST_DIVEND;
					else begin
						if (!add_y[SW-1] && ({rem_q, 1'b0} >= {1'b0, den_q})) begin
							rem_q <= add_y; quo_q <= {quo_q[15:0], 1'b1};
						end else begin
							rem_q <= {rem_q[SW-2:0], 1'b0}; quo_q <= {quo_q[15:0], 1'b0};
						end
						it_q <= it_q + 1'b1;
						if (it_q == 5'd15) state_q <= ST_DIVEND;
					end
				end
				ST_DIVEND: begin
					logic [16:0] q;
					q = (den_q == '0) ? 17'd0 : (num_q >= den_q) ? 17'd65536 : quo_q;
					case (div_sel_q)
						2'd0: begin rec_q <= q; val_q[0] <= den_q != '0; end
						2'd1: begin pre_q <= q; val_q[1] <= den_q != '0; end
						default: begin f1_q <= q; val_q[2] <= den_q != '0; end
					endcase
					if (ovr_q || div_sel_q == 2'd2) state_q <= ST_OUT;
					else begin div_sel_q <= div_sel_q + 1'b1; state_q <= ST_DIVSET; end
				end
				ST_OUT: if (!ovalid_q || m_tready) begin
					ovalid_q <= 1'b1;
					out_q.class_index <= 5'(r_q);
					out_q.true_pos <= sat(ovr_q ? diag_q : tp_q);
					out_q.row_total <= sat(ovr_q ? tot_q : rs_q + miss_q);
					out_q.recall_q16 <= rec_q;
					if (ovr_q) begin
						out_q.false_neg <= '0; out_q.false_pos <= '0;
						out_q.missing_count <= '0; out_q.precision_q16 <= '0;
						out_q.fscore_q16 <= '0; out_q.ratio_valid <= {2'b00, val_q[0]};
						out_q.last <= 1'b1; state_q <= ST_WAIT;
					end else begin
						out_q.false_neg <= sat(fn_q); out_q.false_pos <= sat(fp_q);
						out_q.missing_count <= sat(miss_q); out_q.precision_q16 <= pre_q;
						out_q.fscore_q16 <= f1_q; out_q.ratio_valid <= val_q;
						out_q.last <= 1'b0;
						r_q <= r_q + 1'b1;
						state_q <= (r_q == k - 1'b1) ? ST_OVR : ST_RSTART;
					end
				end
				ST_OVR: begin
					ovr_q <= 1'b1; div_sel_q <= 2'd0; r_q <= k; state_q <= ST_DIVSET;
				end
				ST_WAIT: if (!ovalid_q || m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {out_q.fscore_q16, out_q.precision_q16, out_q.recall_q16,
		out_q.row_total, out_q.missing_count, out_q.false_pos, out_q.false_neg,
		out_q.true_pos, out_q.class_index};
	assign m_tuser  = out_q.ratio_valid;
	assign m_tlast  = out_q.last;
endmodule

FILE: rtl/cma_checker.sv
// Port-level checks for the confusion matrix accumulator.
// Depends only on the top level's ports; bound to it below.
module cma_port_checker (
	input logic clk, arst_n, s_tvalid, s_tready, m_tvalid, m_tready, m_tlast,
	input logic [215:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid) else $error("row after overall row");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during a report");
	a_lastidx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[4:0] != 5'd0) else $error("overall row index zero");
endmodule

bind confusion_matrix_accumulator_top cma_port_checker u_cma_checker (.*);
